// ===== rtl/kvat_pkg.sv =====
package kvat_pkg;

   localparam int REQ_TYPE_BITS = 2;
   localparam int INTER_BITS    = 3;
   localparam int PARTNER_BITS  = 20;
   localparam int VEC_BITS      = 32;
   localparam int DIV_BITS      = 31;
   localparam int INDEX_BITS    = 6;
   localparam int STATUS_BITS   = 3;
   localparam int LEN_BITS      = 7;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_ADD    = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_DIVIDE = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_UPDATED  = 3'd0,
      ST_APPENDED = 3'd1,
      ST_FULL     = 3'd2,
      ST_BAD_TYPE = 3'd3,
      ST_BAD_IDX  = 3'd4,
      ST_DONE     = 3'd5,
      ST_DIV_ZERO = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_ADD_WR,
      S_APPEND,
      S_READ_RD,
      S_READ_OUT,
      S_DIV_NEXT,
      S_DIV_RD,
      S_DIV_RUN,
      S_DIV_WR,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;    // capture request fields
      logic       rd_en;       // issue memory read at rd address
      logic       wr_sum;      // write saturated sums at current entry
      logic       wr_append;   // write new entry at end of list
      logic       div_start;   // start divider on read data
      logic       wr_div;      // write divided vector back
      logic       clear_all;   // zero every count
      logic       out_load;    // load result register
      logic [2:0] out_kind;    // 0 zero, 1 sum, 2 append, 3 read
      status_type out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic type_ok;
      logic key_match;
      logic last_search;   // current index is past the last entry of the list
      logic div_last;      // divide walk has finished the last list
      logic list_full;
      logic index_ok;
      logic div_zero;
      logic div_done;
      logic div_more;      // another entry to divide
      logic out_busy;
   } stat_type;

endpackage

// ===== rtl/kvat_if.sv =====
interface kvat_req_if;
   import kvat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_BITS-1:0] req_type;
   logic [INTER_BITS-1:0]   inter_type;
   logic [PARTNER_BITS-1:0] partner;
   logic signed [VEC_BITS-1:0] vec_x;
   logic signed [VEC_BITS-1:0] vec_y;
   logic signed [VEC_BITS-1:0] vec_z;
   logic [DIV_BITS-1:0]     divisor;
   logic [INDEX_BITS-1:0]   entry_index;
   modport source (output valid, req_type, inter_type, partner, vec_x, vec_y, vec_z,
                   divisor, entry_index, input ready);
   modport sink (input valid, req_type, inter_type, partner, vec_x, vec_y, vec_z,
                 divisor, entry_index, output ready);
endinterface

interface kvat_rsp_if;
   import kvat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATUS_BITS-1:0]  status;
   logic [PARTNER_BITS-1:0] partner_out;
   logic signed [VEC_BITS-1:0] sum_x;
   logic signed [VEC_BITS-1:0] sum_y;
   logic signed [VEC_BITS-1:0] sum_z;
   logic [LEN_BITS-1:0]     list_length;
   modport source (output valid, status, partner_out, sum_x, sum_y, sum_z, list_length,
                   input ready);
   modport sink (input valid, status, partner_out, sum_x, sum_y, sum_z, list_length,
                 output ready);
endinterface

// ===== rtl/kvat_divider.sv =====
// restoring divider, one quotient bit per cycle, three components in parallel
module kvat_divider import kvat_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [3*VEC_BITS-1:0]      num,
   input  logic [DIV_BITS-1:0]        den,
   output logic                       done,
   output logic [3*VEC_BITS-1:0]      quo
);
   localparam int NB = VEC_BITS + FRAC_BITS;
   localparam int CB = $clog2(NB + 1);

   logic [CB-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic [NB-1:0]          dvd_ff [3], dvd_in [3];
   logic [DIV_BITS:0]      rem_ff [3], rem_in [3];
   logic [2:0]             neg_ff, neg_in;
   logic [DIV_BITS-1:0]    den_ff, den_in;

   // control and shift step
   always_comb begin
      logic [DIV_BITS+1:0] trial;
      logic signed [VEC_BITS-1:0] x;
      logic [VEC_BITS:0] mag;
      trial   = '0;
      x       = '0;
      mag     = '0;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      for (int k = 0; k < 3; k++) begin
         dvd_in[k] = dvd_ff[k];
         rem_in[k] = rem_ff[k];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CB'(NB);
         den_in  = den;
         for (int k = 0; k < 3; k++) begin
            x         = num[k*VEC_BITS +: VEC_BITS];
            neg_in[k] = x[VEC_BITS-1];
            mag       = x[VEC_BITS-1] ? (VEC_BITS+1)'(-{x[VEC_BITS-1], x})
                                      : {1'b0, x};
            dvd_in[k] = NB'({mag, {FRAC_BITS{1'b0}}});
            rem_in[k] = '0;
         end
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            // quotient complete, done shown for this cycle
            busy_in = 1'b0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               trial = {rem_ff[k], dvd_ff[k][NB-1]};
               if (trial >= {2'b00, den_ff}) begin
                  rem_in[k] = (DIV_BITS+1)'(trial - {2'b00, den_ff});
                  dvd_in[k] = {dvd_ff[k][NB-2:0], 1'b1};
               end else begin
                  rem_in[k] = trial[DIV_BITS:0];
                  dvd_in[k] = {dvd_ff[k][NB-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      neg_ff <= neg_in;
      for (int k = 0; k < 3; k++) begin
         dvd_ff[k] <= dvd_in[k];
         rem_ff[k] <= rem_in[k];
      end
   end

   assign done = busy_ff && (cnt_ff == '0);

   // sign restore and saturation
   always_comb begin
      logic [NB-1:0] q;
      for (int k = 0; k < 3; k++) begin
         q = dvd_ff[k];
         if (neg_ff[k]) begin
            if (q >= NB'(64'h8000_0000))
               quo[k*VEC_BITS +: VEC_BITS] = 32'h8000_0000;
            else
               quo[k*VEC_BITS +: VEC_BITS] = VEC_BITS'(-q);
         end else if (q > NB'(64'h7FFF_FFFF)) begin
            quo[k*VEC_BITS +: VEC_BITS] = 32'h7FFF_FFFF;
         end else begin
            quo[k*VEC_BITS +: VEC_BITS] = VEC_BITS'(q);
         end
      end
   end
endmodule

// ===== rtl/kvat_datapath.sv =====
module kvat_datapath import kvat_pkg::*; #(
   parameter int LIST_CAPACITY = 64,
   parameter int NUM_LISTS     = 7,
   parameter int KEY_BITS      = 20,
   parameter int FRAC_BITS     = 16
) (
   input  logic     clock,
   input  logic     reset,
   kvat_req_if.sink req,
   kvat_rsp_if.source rsp,
   input  cmd_type  cmd,
   output stat_type stat
);
   localparam int IB    = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CB    = $clog2(LIST_CAPACITY + 1);
   localparam int LB    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int DEPTH = NUM_LISTS * LIST_CAPACITY;
   localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KB    = (KEY_BITS < PARTNER_BITS) ? KEY_BITS : PARTNER_BITS;

   // request capture
   logic [REQ_TYPE_BITS-1:0] rtype_ff;
   logic [INTER_BITS-1:0]    itype_ff;
   logic [KB-1:0]            key_ff;
   logic signed [VEC_BITS-1:0] vx_ff, vy_ff, vz_ff;
   logic [DIV_BITS-1:0]      div_ff;
   logic [INDEX_BITS-1:0]    idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rtype_ff <= req.req_type;
         itype_ff <= req.inter_type;
         key_ff   <= req.partner[KB-1:0];
         vx_ff    <= req.vec_x;
         vy_ff    <= req.vec_y;
         vz_ff    <= req.vec_z;
         div_ff   <= req.divisor;
         idx_ff   <= req.entry_index;
      end
   end

   logic type_ok;
   logic [LB-1:0] lst;
   assign type_ok = 32'(itype_ff) < NUM_LISTS;
   assign lst     = LB'(itype_ff);

   // list counts
   logic [CB-1:0] cnt_ff [NUM_LISTS];
   logic [CB-1:0] cur_cnt;
   assign cur_cnt = cnt_ff[lst];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int k = 0; k < NUM_LISTS; k++) cnt_ff[k] <= '0;
      end else if (cmd.wr_append) begin
         cnt_ff[lst] <= cur_cnt + 1'b1;
      end
   end

   // walk pointer: list and index used for search and divide
   logic [IB-1:0] wi_ff;
   logic [LB-1:0] wl_ff;
   logic          walk_rd;
   logic          wrap_ff;

   logic [AB-1:0] rd_addr, wr_addr, cur_addr;
   logic [AB-1:0] walk_addr;
   assign walk_addr = AB'(32'(wl_ff) * LIST_CAPACITY + 32'(wi_ff));

   // memory
   logic [KB-1:0]        mkey [DEPTH];
   logic [VEC_BITS-1:0]  mx [DEPTH], my [DEPTH], mz [DEPTH];
   logic [KB-1:0]        rkey_ff;
   logic signed [VEC_BITS-1:0] rx_ff, ry_ff, rz_ff;
   logic [AB-1:0]        raddr_ff;

   assign rd_addr = (rtype_ff == REQ_READ)
                    ? AB'(32'(lst) * LIST_CAPACITY + 32'(idx_ff)) : walk_addr;

   // saturating sums
   function automatic logic [VEC_BITS-1:0] sat_add(input logic signed [VEC_BITS-1:0] a,
                                                    input logic signed [VEC_BITS-1:0] b);
      logic signed [VEC_BITS:0] s;
      s = VEC_BITS'(0) + {a[VEC_BITS-1], a} + {b[VEC_BITS-1], b};
      if (s[VEC_BITS] != s[VEC_BITS-1])
         return s[VEC_BITS] ? {1'b1, {(VEC_BITS-1){1'b0}}} : {1'b0, {(VEC_BITS-1){1'b1}}};
      return s[VEC_BITS-1:0];
   endfunction

   logic [VEC_BITS-1:0] nx, ny, nz;
   assign nx = sat_add(rx_ff, vx_ff);
   assign ny = sat_add(ry_ff, vy_ff);
   assign nz = sat_add(rz_ff, vz_ff);

   logic [3*VEC_BITS-1:0] quo;
   logic                  div_done;

   assign cur_addr = raddr_ff;
   assign wr_addr  = cmd.wr_append
                     ? AB'(32'(lst) * LIST_CAPACITY + 32'(cur_cnt)) : cur_addr;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rkey_ff  <= mkey[rd_addr];
         rx_ff    <= mx[rd_addr];
         ry_ff    <= my[rd_addr];
         rz_ff    <= mz[rd_addr];
         raddr_ff <= rd_addr;
      end
      if (cmd.wr_append) begin
         mkey[wr_addr] <= key_ff;
         mx[wr_addr]   <= vx_ff;
         my[wr_addr]   <= vy_ff;
         mz[wr_addr]   <= vz_ff;
      end else if (cmd.wr_sum) begin
         mx[wr_addr] <= nx;
         my[wr_addr] <= ny;
         mz[wr_addr] <= nz;
      end else if (cmd.wr_div) begin
         mx[wr_addr] <= quo[0 +: VEC_BITS];
         my[wr_addr] <= quo[VEC_BITS +: VEC_BITS];
         mz[wr_addr] <= quo[2*VEC_BITS +: VEC_BITS];
      end
   end

   // walk pointer advance: next list entry, skipping lists that are done
   logic [IB-1:0] wi_in;
   logic [LB-1:0] wl_in;
   logic          more;
   logic          list_done;
   logic [CB-1:0] wl_cnt;
   assign wl_cnt    = cnt_ff[wl_ff];
   assign walk_rd   = cmd.rd_en && (rtype_ff != REQ_READ);
   assign list_done = wrap_ff || !more;

   always_comb begin
      wi_in = wi_ff;
      wl_in = wl_ff;
      if (cmd.load_req) begin
         wi_in = '0;
         wl_in = (req.req_type == REQ_DIVIDE) ? '0 : LB'(req.inter_type);
      end else if (walk_rd) begin
         wi_in = wi_ff + 1'b1;
      end else if (rtype_ff == REQ_DIVIDE && list_done && cmd.div_start == 1'b0
                   && 32'(wl_ff) < NUM_LISTS - 1 && cmd.rd_en == 1'b0) begin
         wi_in = '0;
         wl_in = wl_ff + 1'b1;
      end
   end

   // entry to visit exists at pointer
   assign more = (CB'(wi_ff) < wl_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff <= '0;
         wl_ff <= '0;
         wrap_ff <= 1'b0;
      end else begin
         // index wraps to zero past capacity; remember that for the list end test
         wrap_ff <= cmd.load_req ? 1'b0
                    : (walk_rd && wi_ff == IB'(LIST_CAPACITY - 1)) ? 1'b1
                    : (wl_in != wl_ff) ? 1'b0 : wrap_ff;
         wi_ff <= wi_in;
         wl_ff <= wl_in;
      end
   end

   kvat_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({rz_ff, ry_ff, rx_ff}),
      .den   (div_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // status to controller
   assign stat.type_ok     = type_ok;
   assign stat.key_match   = (rkey_ff == key_ff);
   assign stat.last_search = wrap_ff || !(CB'(wi_ff) < cur_cnt);
   assign stat.div_last    = list_done && (32'(wl_ff) >= NUM_LISTS - 1);
   assign stat.list_full   = !(cur_cnt < CB'(LIST_CAPACITY));
   assign stat.index_ok    = (32'(idx_ff) < 32'(cur_cnt)) && (32'(idx_ff) < LIST_CAPACITY);
   assign stat.div_zero    = (div_ff == '0);
   assign stat.div_done    = div_done;
   assign stat.div_more    = !list_done;
   assign stat.out_busy    = rsp.valid && !rsp.ready;

   // result register
   logic                    ov_ff;
   logic [STATUS_BITS-1:0]  st_ff;
   logic [PARTNER_BITS-1:0] po_ff;
   logic [VEC_BITS-1:0]     ox_ff, oy_ff, oz_ff;
   logic [LEN_BITS-1:0]     ol_ff;
   logic [CB-1:0]           len_now;
   assign len_now = cmd.wr_append ? CB'(cur_cnt + 1'b1)
                    : (cmd.clear_all ? '0 : cur_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ov_ff <= 1'b1;
      end else if (rsp.ready) begin
         ov_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         st_ff <= cmd.out_status;
         ol_ff <= type_ok ? LEN_BITS'(len_now) : '0;
         po_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= '0;
         unique case (cmd.out_kind)
            3'd1: begin
               ox_ff <= nx;
               oy_ff <= ny;
               oz_ff <= nz;
            end
            3'd2: begin
               ox_ff <= vx_ff;
               oy_ff <= vy_ff;
               oz_ff <= vz_ff;
            end
            3'd3: begin
               po_ff <= PARTNER_BITS'(rkey_ff);
               ox_ff <= rx_ff;
               oy_ff <= ry_ff;
               oz_ff <= rz_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid       = ov_ff;
   assign rsp.status      = st_ff;
   assign rsp.partner_out = po_ff;
   assign rsp.sum_x       = ox_ff;
   assign rsp.sum_y       = oy_ff;
   assign rsp.sum_z       = oz_ff;
   assign rsp.list_length = ol_ff;

   // an append never pushes a count past capacity
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |-> cur_cnt < CB'(LIST_CAPACITY))
      else $error("append into full list");
   // result register is not overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp.valid && !rsp.ready))
      else $error("result overwritten");
   // a clear leaves the count of list zero at zero
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> cnt_ff[0] == '0)
      else $error("clear missed");
endmodule

// ===== rtl/kvat_ctrl.sv =====
module kvat_ctrl import kvat_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [REQ_TYPE_BITS-1:0] req_code,
   input  stat_type stat,
   output cmd_type  cmd,
   output state_type state
);
   state_type state_ff, state_in;
   req_code_type rc;
   logic [REQ_TYPE_BITS-1:0] rc_ff;
   assign rc = req_code_type'(rc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (cmd.load_req) rc_ff <= req_code;
   end

   assign state = state_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.out_status = ST_DONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !stat.out_busy;
            if (req_valid && !stat.out_busy) begin
               cmd.load_req = 1'b1;
               state_in     = S_RESP;
               unique case (req_code_type'(req_code))
                  REQ_ADD:    state_in = S_SEARCH_RD;
                  REQ_READ:   state_in = S_READ_RD;
                  REQ_DIVIDE: state_in = S_DIV_NEXT;
                  REQ_CLEAR:  state_in = S_RESP;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_SEARCH_RD: begin
            if (!stat.type_ok) begin
               cmd.out_load = 1'b1;
               cmd.out_status = ST_BAD_TYPE;
               state_in = S_IDLE;
            end else if (stat.last_search) begin
               state_in = S_APPEND;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SEARCH_CMP;
            end
         end
         S_SEARCH_CMP: begin
            if (stat.key_match) begin
               cmd.wr_sum     = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_kind   = 3'd1;
               cmd.out_status = ST_UPDATED;
               state_in       = S_IDLE;
            end else begin
               state_in = S_SEARCH_RD;
            end
         end
         S_APPEND: begin
            cmd.out_load = 1'b1;
            if (stat.list_full) begin
               cmd.out_status = ST_FULL;
            end else begin
               cmd.wr_append  = 1'b1;
               cmd.out_kind   = 3'd2;
               cmd.out_status = ST_APPENDED;
            end
            state_in = S_IDLE;
         end
         S_READ_RD: begin
            if (!stat.type_ok || !stat.index_ok) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = stat.type_ok ? ST_BAD_IDX : ST_BAD_TYPE;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_READ_OUT;
            end
         end
         S_READ_OUT: begin
            cmd.out_load   = 1'b1;
            cmd.out_kind   = 3'd3;
            cmd.out_status = ST_DONE;
            state_in       = S_IDLE;
         end
         S_DIV_NEXT: begin
            if (stat.div_zero) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_DIV_ZERO;
               state_in       = S_IDLE;
            end else if (stat.div_more) begin
               cmd.rd_en = 1'b1;
               state_in  = S_DIV_RD;
            end else if (stat.div_last) begin
               state_in = S_RESP;
            end else begin
               // walk steps to the next list this cycle
               state_in = S_DIV_NEXT;
            end
         end
         S_DIV_RD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (stat.div_done) state_in = S_DIV_WR;
         end
         S_DIV_WR: begin
            cmd.wr_div = 1'b1;
            state_in   = S_DIV_NEXT;
         end
         S_RESP: begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_DONE;
            cmd.clear_all  = (rc == REQ_CLEAR);
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a request is only taken in idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> state_ff == S_IDLE)
      else $error("request taken while busy");
   // a divider start is followed by the run state
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == S_DIV_RUN)
      else $error("divider start lost");
   // every result load returns to idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE)
      else $error("result without return to idle");
endmodule

// ===== rtl/keyed_vector_accumulate_table_top.sv =====
// Keyed vector accumulate table: NUM_LISTS lists of LIST_CAPACITY entries, each a
// partner key with a saturating Q16.16 force vector, held in one single-port memory.
// One request at a time. An add reads each stored key in S_SEARCH_RD and compares
// it in S_SEARCH_CMP; a read passes S_READ_RD and S_READ_OUT, a clear S_RESP alone.
// Divide-all runs a bit-serial divider of 32+FRAC_BITS steps on each stored entry and
// walks the lists in order, so its length follows the total number of entries. A result
// waits in an output register; the next request is taken once that register is free.
// No clearing pass is needed after reset: the per-list counts reset to zero.
module keyed_vector_accumulate_table_top import kvat_pkg::*; #(
   parameter int LIST_CAPACITY = 64,
   parameter int NUM_LISTS     = 7,
   parameter int KEY_BITS      = 20,
   parameter int FRAC_BITS     = 16
) (
   input logic        clock,
   input logic        reset,
   kvat_req_if.sink   req,
   kvat_rsp_if.source rsp
);
   cmd_type   cmd;
   stat_type  stat;
   state_type state;

   kvat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_code  (req.req_type),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   kvat_datapath #(
      .LIST_CAPACITY (LIST_CAPACITY),
      .NUM_LISTS     (NUM_LISTS),
      .KEY_BITS      (KEY_BITS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .stat  (stat)
   );

   // busy states never accept a request
   assert property (@(posedge clock) disable iff (reset)
      (state != S_IDLE) |-> !req.ready)
      else $error("ready outside idle");
   // a shown result holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.status))
      else $error("result dropped");
   // divide-zero status only when the divisor is zero
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.out_status == ST_DIV_ZERO |-> stat.div_zero)
      else $error("bad divide-zero status");
endmodule
